// ===== sv/sobel_edge_magnitude_rgb_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the Sobel edge magnitude block
// Shared property forms with a common clock and reset.
// ---------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_TOP_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_TOP_ASSERT_SVH

// The condition implies the consequence in the same cycle.
`define SEM_ASSERT_SAME(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// The condition implies the consequence in the next cycle.
`define SEM_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sem_pkg.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude package
// Item types, field widths and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none
package sem_pkg;

   localparam int CHAN_W     = 8;
   localparam int PIX_W      = 3 * CHAN_W;
   localparam int GRAD_W     = 11;
   localparam int SUM_W      = 21;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [SUM_W-1:0]  MAG_LIMIT = 21'd65025;
   localparam logic [CHAN_W-1:0] MAG_MAX   = 8'd255;

   typedef struct packed {
      logic              action;
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } sem_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_edge;
      logic [CHAN_W-1:0] green_edge;
      logic [CHAN_W-1:0] blue_edge;
      logic              frame_done;
   } sem_rsp_type;

endpackage
`default_nettype wire

// ===== sv/sem_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module sem_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== sv/sem_root.sv =====
// ---------------------------------------------------------------------------
// Sobel magnitude unit
// Squares the gradients, then finds the rounded square root one bit a cycle, saturating at 255.
// ---------------------------------------------------------------------------
`default_nettype none
module sem_root (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [sem_pkg::GRAD_W-1:0]  gx,
   input  wire logic signed [sem_pkg::GRAD_W-1:0]  gy,
   output logic                                    done,
   output logic             [sem_pkg::CHAN_W-1:0]  mag
);
   import sem_pkg::*;

   typedef enum logic [3:0] {
      RT_IDLE = 4'b0001,
      RT_SQ   = 4'b0010,
      RT_ITER = 4'b0100,
      RT_FIN  = 4'b1000
   } rt_state_type;

   rt_state_type               state_ff, state_in;
   logic signed [GRAD_W-1:0]   gx_ff, gy_ff;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CHAN_W-1:0]          q_ff, q_in;
   logic [2:0]                 bit_ff, bit_in;
   logic [CHAN_W-1:0]          mag_ff, mag_in;
   logic                       done_ff, done_in;
   logic signed [2*GRAD_W-1:0] sqx, sqy;
   logic [CHAN_W-1:0]          trial;
   logic [2*CHAN_W-1:0]        trial_sq;
   logic [2*CHAN_W-1:0]        q_sq;
   logic [2*CHAN_W:0]          round_lim;

   always_comb begin
      sqx       = gx_ff * gx_ff;
      sqy       = gy_ff * gy_ff;
      trial     = q_ff | (CHAN_W'(1) << bit_ff);
      trial_sq  = trial * trial;
      q_sq      = q_ff * q_ff;
      round_lim = {1'b0, q_sq} + {{(CHAN_W+1){1'b0}}, q_ff};
      state_in  = state_ff;
      sum_in    = sum_ff;
      q_in      = q_ff;
      bit_in    = bit_ff;
      mag_in    = mag_ff;
      done_in   = 1'b0;
      case (state_ff)
         RT_IDLE: begin
            if (start) begin
               state_in = RT_SQ;
            end
         end
         RT_SQ: begin
            sum_in   = SUM_W'(sqx) + SUM_W'(sqy);
            q_in     = '0;
            bit_in   = 3'd7;
            state_in = RT_ITER;
         end
         RT_ITER: begin
            if ({{(SUM_W-2*CHAN_W){1'b0}}, trial_sq} <= sum_ff) begin
               q_in = trial;
            end
            bit_in = bit_ff - 3'd1;
            if (bit_ff == 3'd0) begin
               state_in = RT_FIN;
            end
         end
         RT_FIN: begin
            if (sum_ff > MAG_LIMIT) begin
               mag_in = MAG_MAX;
            end else if (sum_ff > {{(SUM_W-2*CHAN_W-1){1'b0}}, round_lim}) begin
               mag_in = q_ff + CHAN_W'(1);
            end else begin
               mag_in = q_ff;
            end
            done_in  = 1'b1;
            state_in = RT_IDLE;
         end
         default: state_in = RT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RT_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      if (start && state_ff == RT_IDLE) begin
         gx_ff <= gx;
         gy_ff <= gy;
      end
      sum_ff <= sum_in;
      q_ff   <= q_in;
      bit_ff <= bit_in;
      mag_ff <= mag_in;
   end

   assign done = done_ff;
   assign mag  = mag_ff;
endmodule
`default_nettype wire

// ===== sv/sobel_edge_magnitude_rgb_top.sv =====
// An item is taken in the idle state, read from the line store in the next cycle, windowed
// in the calculate state, and its result is offered once the square root is done. No new
// item is taken until that result is registered; the root and receiver stalls pace input.
// Items with no result stop after the calculate state; ignored items stay in the idle state.
// Reset is synchronous; the line store needs no clearing pass and is masked until written.
// ---------------------------------------------------------------------------
// Sobel edge magnitude, RGB
// Streaming 3x3 Sobel filter with two line stores held in one RAM.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sobel_edge_magnitude_rgb_top_assert.svh"
module sobel_edge_magnitude_rgb_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire sem_pkg::sem_req_type                  req_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output sem_pkg::sem_rsp_type                       rsp_data,
   input  wire logic                                  csr_we,
   input  wire logic [sem_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [sem_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import sem_pkg::*;

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT + 2);
   localparam int DW = $clog2(MAX_WIDTH + 2);
   localparam int WID_RST = (1024 > MAX_WIDTH) ? MAX_WIDTH : 1024;
   localparam int HGT_RST = (768 > MAX_HEIGHT) ? MAX_HEIGHT : 768;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_RD   = 5'b00010,
      ST_CALC = 5'b00100,
      ST_ROOT = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [WW-1:0]        wid_ff, wid_in;
   logic [HW-1:0]        hgt_ff, hgt_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [DW-1:0]        drains_ff, drains_in;
   logic [PIX_W-1:0]     taps_ff [9];
   logic [PIX_W-1:0]     taps_in [9];
   logic [PIX_W-1:0]     px_ff;
   logic                 drain_ff;
   logic                 last_ff, last_in;
   logic                 start_ff, start_in;
   logic signed [GRAD_W-1:0] gx_ff [3];
   logic signed [GRAD_W-1:0] gy_ff [3];
   logic signed [GRAD_W-1:0] gx_in [3];
   logic signed [GRAD_W-1:0] gy_in [3];
   logic                 rsp_valid_ff, rsp_valid_in;
   sem_rsp_type          rsp_data_ff, rsp_data_in;
   logic [2*PIX_W-1:0]   rd_data;
   logic [PIX_W-1:0]     up_pix, mid_pix;
   logic [PIX_W-1:0]     win [9];
   logic [CHAN_W-1:0]    tv [9];
   logic                 ok [9];
   logic                 c1, produce, ok_c0, ok_c2, ok_r0, ok_r2;
   logic [31:0]          crow, ccol, wnext;
   logic                 req_fire;
   logic [CHAN_W-1:0]    mag [3];
   logic                 done [3];
   logic [CHAN_W+1:0]    lsum, rsum, tsum, bsum;
   logic [WW-1:0]        wid_clamp;
   logic [HW-1:0]        hgt_clamp;

   sem_ram #(.WIDTH(2 * PIX_W), .DEPTH(MAX_WIDTH)) u_lines (
      .clock   (clock),
      .wr_en   (state_ff == ST_CALC),
      .wr_addr (col_ff),
      .wr_data ({mid_pix, px_ff}),
      .rd_en   (state_ff == ST_RD),
      .rd_addr (col_ff),
      .rd_data (rd_data)
   );

   for (genvar g = 0; g < 3; g++) begin : g_root
      sem_root u_root (
         .clock (clock),
         .reset (reset),
         .start (start_ff),
         .gx    (gx_ff[g]),
         .gy    (gy_ff[g]),
         .done  (done[g]),
         .mag   (mag[g])
      );
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign up_pix    = rd_data[2*PIX_W-1:PIX_W];
   assign mid_pix   = rd_data[PIX_W-1:0];

   // Register values saturate into their legal range.
   always_comb begin
      if (csr_wdata[WIDTH_W-1:0] == '0) begin
         wid_clamp = WW'(1);
      end else if (32'(csr_wdata[WIDTH_W-1:0]) > 32'(MAX_WIDTH)) begin
         wid_clamp = WW'(MAX_WIDTH);
      end else begin
         wid_clamp = WW'(csr_wdata[WIDTH_W-1:0]);
      end
      if (csr_wdata[HEIGHT_W-1:0] == '0) begin
         hgt_clamp = HW'(1);
      end else if (32'(csr_wdata[HEIGHT_W-1:0]) > 32'(MAX_HEIGHT)) begin
         hgt_clamp = HW'(MAX_HEIGHT);
      end else begin
         hgt_clamp = HW'(csr_wdata[HEIGHT_W-1:0]);
      end
   end

   // Window after the shift; the right column takes the store outputs and the new pixel.
   always_comb begin
      for (int y = 0; y < 3; y++) begin
         win[y*3]   = taps_ff[y*3+1];
         win[y*3+1] = taps_ff[y*3+2];
      end
      win[2] = up_pix;
      win[5] = mid_pix;
      win[8] = px_ff;
      c1      = (col_ff != '0);
      crow    = c1 ? 32'(row_ff) - 32'd1 : 32'(row_ff) - 32'd2;
      ccol    = c1 ? 32'(col_ff) - 32'd1 : 32'(wid_ff) - 32'd1;
      produce = (32'(row_ff) >= 32'd2) || (32'(row_ff) == 32'd1 && c1);
      ok_c0   = (ccol != 32'd0);
      ok_c2   = c1;
      ok_r0   = (crow != 32'd0);
      ok_r2   = (crow + 32'd1 < 32'(hgt_ff));
      for (int y = 0; y < 3; y++) begin
         ok[y*3]   = ok_c0;
         ok[y*3+1] = 1'b1;
         ok[y*3+2] = ok_c2;
      end
      for (int x = 0; x < 3; x++) begin
         ok[x]   = ok[x] && ok_r0;
         ok[6+x] = ok[6+x] && ok_r2;
      end
      last_in = (crow == 32'(hgt_ff) - 32'd1) && (ccol == 32'(wid_ff) - 32'd1);
      for (int ch = 0; ch < 3; ch++) begin
         for (int k = 0; k < 9; k++) begin
            tv[k] = ok[k] ? win[k][(2-ch)*CHAN_W +: CHAN_W] : '0;
         end
         lsum = {2'b0, tv[0]} + {1'b0, tv[3], 1'b0} + {2'b0, tv[6]};
         rsum = {2'b0, tv[2]} + {1'b0, tv[5], 1'b0} + {2'b0, tv[8]};
         tsum = {2'b0, tv[0]} + {1'b0, tv[1], 1'b0} + {2'b0, tv[2]};
         bsum = {2'b0, tv[6]} + {1'b0, tv[7], 1'b0} + {2'b0, tv[8]};
         gx_in[ch] = $signed({1'b0, rsum}) - $signed({1'b0, lsum});
         gy_in[ch] = $signed({1'b0, bsum}) - $signed({1'b0, tsum});
      end
   end

   always_comb begin
      state_in     = state_ff;
      wid_in       = wid_ff;
      hgt_in       = hgt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      drains_in    = drains_ff;
      taps_in      = taps_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wnext        = 32'(col_ff) + 32'd1;
      case (state_ff)
         ST_IDLE: begin
            if (csr_we) begin
               if (csr_index == CSR_IMAGE_WIDTH) begin
                  wid_in = wid_clamp;
               end else begin
                  hgt_in = hgt_clamp;
               end
               col_in    = '0;
               row_in    = '0;
               drains_in = '0;
               for (int k = 0; k < 9; k++) begin
                  taps_in[k] = '0;
               end
            end else if (req_fire && (drains_ff != '0 || !req_data.action)) begin
               state_in = ST_RD;
            end
         end
         ST_RD: state_in = ST_CALC;
         ST_CALC: begin
            taps_in = win;
            if (!drain_ff && 32'(row_ff) == 32'(hgt_ff) - 32'd1
                && 32'(col_ff) == 32'(wid_ff) - 32'd1) begin
               drains_in = DW'(32'(wid_ff) + 32'd1);
            end else if (drain_ff) begin
               drains_in = drains_ff - DW'(1);
            end
            if (wnext >= 32'(wid_ff)) begin
               col_in = '0;
               row_in = row_ff + RW'(1);
            end else begin
               col_in = CW'(wnext);
            end
            if (drain_ff && drains_ff == DW'(1)) begin
               col_in = '0;
               row_in = '0;
            end
            if (produce) begin
               start_in = 1'b1;
               state_in = ST_ROOT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_ROOT: begin
            if (done[0]) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{red_edge: mag[0], green_edge: mag[1],
                                blue_edge: mag[2], frame_done: last_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wid_ff       <= WW'(WID_RST);
         hgt_ff       <= HW'(HGT_RST);
         col_ff       <= '0;
         row_ff       <= '0;
         drains_ff    <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 9; k++) begin
            taps_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         wid_ff       <= wid_in;
         hgt_ff       <= hgt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         drains_ff    <= drains_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         taps_ff      <= taps_in;
      end
      if (req_fire) begin
         drain_ff <= (drains_ff != '0);
         px_ff    <= (drains_ff != '0) ? '0
                     : {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
      if (state_ff == ST_CALC) begin
         last_ff <= last_in;
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SEM_ASSERT_SAME(a_col_in_row, state_ff == ST_IDLE, 32'(col_ff) < 32'(wid_ff),
      "column position beyond image width")
   `SEM_ASSERT_SAME(a_drains_bound, 1'b1, 32'(drains_ff) <= 32'(wid_ff) + 32'd1,
      "drain count above width plus one")
   `SEM_ASSERT_SAME(a_root_done, done[0], state_ff == ST_ROOT && done[1] && done[2],
      "magnitude units out of step with the sequencer")
   `SEM_ASSERT_NEXT(a_frame_end, state_ff == ST_OUT && rsp_valid_in && last_ff,
      drains_ff == '0 && col_ff == '0 && row_ff == '0,
      "frame end result without a restart of the raster position")
endmodule
`default_nettype wire

// ===== dv/sobel_edge_magnitude_rgb_top_tb.sv =====
// ---------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Streams RGB frames of many geometries through the filter, predicts every
// edge item with a behavioral model kept in step with the input, and checks
// each result in order under random sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none
module sobel_edge_magnitude_rgb_top_tb;
   import sem_pkg::*;

   localparam int LINE_DEPTH  = 1024;
   localparam int HEIGHT_MAX  = 4096;
   localparam int SETTLE      = 40;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int KX[9] = '{-1, 0, 1, -2, 0, 2, -1, 0, 1};
   localparam int KY[9] = '{-1, -2, -1, 0, 0, 0, 1, 2, 1};

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   sem_req_type           req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   sem_rsp_type           rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   sobel_edge_magnitude_rgb_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Shadow of the filter state.
   logic [PIX_W-1:0]      line_upper [LINE_DEPTH];
   logic [PIX_W-1:0]      line_middle [LINE_DEPTH];
   logic [8:0][PIX_W-1:0] taps = '0;
   int                    col_pos = 0;
   int                    row_pos = 0;
   int                    drains_left = 0;
   int                    cfg_width = 1024;
   int                    cfg_height = 768;

   sem_rsp_type expected_edges[$];
   int errors = 0;
   int items_sent = 0;
   int edges_seen = 0;
   int frames_seen = 0;
   int cycles = 0;
   int burst_left = 0;
   int hold_req_count = 0;
   int hold_seen = 0;
   int hold_off = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   initial begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
         line_upper[i] = '0;
         line_middle[i] = '0;
      end
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d items outstanding.", cycles,
                  expected_edges.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver: random stall patterns, plus a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_req_count != hold_seen) begin
         hold_seen <= hold_req_count;
         hold_off  <= 400;
         rsp_ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off  <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (stall_phase == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            stall_phase <= $urandom_range(20, 200);
         end else begin
            stall_phase <= stall_phase - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Values sampled mid-cycle are the ones the next rising edge accepts.
   always @(negedge clock) begin
      sem_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_edges.size() == 0) begin
            $error("Unexpected edge item %h with nothing pending", rsp_data);
            errors++;
         end else begin
            want = expected_edges.pop_front();
            edges_seen++;
            if (want.frame_done) frames_seen++;
            if (rsp_data.red_edge !== want.red_edge) begin
               $error("red_edge expected %0d actual %0d", want.red_edge, rsp_data.red_edge);
               errors++;
            end
            if (rsp_data.green_edge !== want.green_edge) begin
               $error("green_edge expected %0d actual %0d", want.green_edge,
                      rsp_data.green_edge);
               errors++;
            end
            if (rsp_data.blue_edge !== want.blue_edge) begin
               $error("blue_edge expected %0d actual %0d", want.blue_edge, rsp_data.blue_edge);
               errors++;
            end
            if (rsp_data.frame_done !== want.frame_done) begin
               $error("frame_done expected %0d actual %0d", want.frame_done,
                      rsp_data.frame_done);
               errors++;
            end
         end
      end
   end

   // Exact rounded magnitude of one channel over the masked 3x3 window.
   function automatic logic [7:0] channel_mag(input logic [8:0][PIX_W-1:0] win,
                                              input logic [8:0] ok, input int sh);
      int gx, gy, v, s, q, t;
      gx = 0;
      gy = 0;
      for (int k = 0; k < 9; k++) begin
         if (ok[k]) begin
            v = (win[k] >> sh) & 8'hFF;
            gx += v * KX[k];
            gy += v * KY[k];
         end
      end
      s = gx * gx + gy * gy;
      if (s > 65025) return 8'd255;
      q = 0;
      for (int b = 128; b != 0; b >>= 1) begin
         t = q | b;
         if (t * t <= s) q = t;
      end
      if (s > q * q + q) q++;
      return q[7:0];
   endfunction

   function automatic void predict_edges(input sem_req_type it);
      logic [PIX_W-1:0] px, u, m;
      logic [8:0][PIX_W-1:0] prev, win;
      logic [8:0] ok;
      int r, c, crow, ccol;
      bit drain;
      sem_rsp_type res;
      drain = drains_left != 0;
      if (!drain && it.action) return;
      px = drain ? '0 : {it.red_in, it.green_in, it.blue_in};
      r = row_pos;
      c = col_pos % LINE_DEPTH;
      u = line_upper[c];
      m = line_middle[c];
      line_upper[c] = m;
      line_middle[c] = px;
      prev = taps;
      for (int y = 0; y < 3; y++) begin
         taps[y*3]   = taps[y*3+1];
         taps[y*3+1] = taps[y*3+2];
      end
      taps[2] = u;
      taps[5] = m;
      taps[8] = px;
      if (r >= 2 || (r == 1 && c >= 1)) begin
         ok = '1;
         if (c >= 1) begin
            crow = r - 1;
            ccol = c - 1;
            win = taps;
         end else begin
            // The row just wrapped: the centre is the last pixel of the row before.
            crow = r - 2;
            ccol = cfg_width - 1;
            for (int y = 0; y < 3; y++) begin
               win[y*3]   = prev[y*3+1];
               win[y*3+1] = prev[y*3+2];
               win[y*3+2] = '0;
               ok[y*3+2]  = 1'b0;
            end
         end
         if (ccol == 0) {ok[0], ok[3], ok[6]} = 3'b000;
         if (crow == 0) ok[2:0] = 3'b000;
         if (crow + 1 >= cfg_height) ok[8:6] = 3'b000;
         res.red_edge   = channel_mag(win, ok, 16);
         res.green_edge = channel_mag(win, ok, 8);
         res.blue_edge  = channel_mag(win, ok, 0);
         res.frame_done = (crow == cfg_height - 1) && (ccol == cfg_width - 1);
         expected_edges.push_back(res);
      end
      if (!drain && r == cfg_height - 1 && c == cfg_width - 1) drains_left = cfg_width + 1;
      else if (drain) drains_left--;
      c++;
      if (c >= cfg_width) begin
         c = 0;
         r++;
      end
      col_pos = c;
      row_pos = r;
      if (drain && drains_left == 0) begin
         col_pos = 0;
         row_pos = 0;
      end
   endfunction

   task automatic send_item(input sem_req_type it);
      bit got;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      do begin
         @(negedge clock);
         got = req_ready;
         @(posedge clock);
      end while (!got);
      predict_edges(it);
      items_sent++;
   endtask

   // Drop valid and let every pending edge item come back, then let the pipe settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_edges.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      int v;
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) begin
         v = val & 13'h7FF;
         cfg_width = (v < 1) ? 1 : (v > LINE_DEPTH) ? LINE_DEPTH : v;
      end else begin
         v = val;
         cfg_height = (v < 1) ? 1 : (v > HEIGHT_MAX) ? HEIGHT_MAX : v;
      end
      col_pos = 0;
      row_pos = 0;
      drains_left = 0;
      taps = '0;
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h);
      wait_idle();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
   endtask

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic sem_req_type make_pixel(input bit pattern, input int i);
      sem_req_type it;
      it.action = 1'b0;
      if (pattern) begin
         it.red_in   = ((i + i / cfg_width) % 2) ? 8'd255 : 8'd0;
         it.green_in = ~it.red_in;
         it.blue_in  = 8'd255;
      end else begin
         it.red_in   = pick_channel();
         it.green_in = pick_channel();
         it.blue_in  = pick_channel();
      end
      return it;
   endfunction

   // One frame of pixels, optionally with stray drain ticks that the block ignores,
   // followed by the flush when the whole frame is sent; a flush item may carry either action.
   task automatic send_frame(input bit pattern, input bit noise, input int npix);
      sem_req_type it;
      for (int i = 0; i < npix; i++) begin
         if (noise && $urandom_range(0, 15) == 0) begin
            it = make_pixel(1'b0, 0);
            it.action = 1'b1;
            send_item(it);
         end
         send_item(make_pixel(pattern, i));
      end
      if (npix == cfg_width * cfg_height) begin
         for (int i = 0; i <= cfg_width; i++) begin
            it = make_pixel(1'b0, 0);
            it.action = ($urandom_range(0, 5) != 0);
            send_item(it);
         end
      end
   endtask

   task automatic test_tiny_frames();
      sem_req_type it;
      // A width with zero in its low 11 bits and a zero height saturate to a single-pixel frame.
      set_geometry(13'h1800, 13'd0);
      it = '0;
      it.action = 1'b1;
      send_item(it);
      send_frame(1'b0, 1'b0, 1);
      send_frame(1'b0, 1'b0, 1);
      set_geometry(13'd3, 13'd3);
      send_frame(1'b1, 1'b0, 9);
   endtask

   task automatic test_special_items();
      sem_req_type it;
      set_geometry(13'd4, 13'd3);
      it = '0;
      it.action = 1'b1;
      send_item(it);
      send_frame(1'b1, 1'b1, 12);
      // A second frame follows; all its flush items, sent as pixels, still act as flush.
      for (int i = 0; i < 12; i++) send_item(make_pixel(1'b0, i));
      for (int i = 0; i <= cfg_width; i++) send_item(make_pixel(1'b0, i));
   endtask

   // The width saturates to the full line store; a few pixels past the first row
   // show the wrap at the last column.
   task automatic test_wide_frame();
      set_geometry(13'd2047, 13'd2);
      send_frame(1'b1, 1'b0, cfg_width + 8);
   endtask

   // The height saturates to its maximum, so no bottom row is reached here.
   task automatic test_tall_frame();
      set_geometry(13'd1, 13'd8191);
      send_frame(1'b0, 1'b0, 64);
   endtask

   task automatic test_backpressure();
      set_geometry(13'd16, 13'd4);
      hold_req_count++;
      send_frame(1'b0, 1'b0, 64);
      wait_idle();
   endtask

   task automatic test_random_frames();
      int start, w, h;
      start = items_sent;
      while (items_sent - start < 120) begin
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
         h = $urandom_range(1, 6);
         set_geometry(CSR_DATA_W'(w), CSR_DATA_W'(h));
         if ($urandom_range(0, 4) == 0) send_frame(1'b0, 1'b1, $urandom_range(0, w * h - 1));
         else send_frame($urandom_range(0, 5) == 0, 1'b1, w * h);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tiny_frames();
      test_special_items();
      test_wide_frame();
      test_tall_frame();
      test_backpressure();
      test_random_frames();
      wait_idle();
      $display("Sent %0d items over geometries from 1x1 up to 1024 wide and 4096 tall.",
               items_sent);
      $display("Checked %0d edge items closing %0d frames.", edges_seen, frames_seen);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/sem_pkg.sv
sv/sem_ram.sv
sv/sem_root.sv
sv/sobel_edge_magnitude_rgb_top.sv
dv/sobel_edge_magnitude_rgb_top_tb.sv
